[hdl/umsr_pkg.sv]
// Shared types and constants for the USB-MIDI SysEx reassembler.
// Used by every module under hdl; depends on nothing else.
package umsr_pkg;

  // Message buffer geometry. The buffer is split into byte banks so that the
  // up to three bytes of one event land in distinct banks.
  localparam int BUF_BYTES = 256;
  localparam int ADDR_W    = $clog2(BUF_BYTES);
  localparam int CNT_W     = ADDR_W + 1;
  localparam int BANK_W    = 2;
  localparam int BANKS     = 1 << BANK_W;
  localparam int ROW_W     = ADDR_W - BANK_W;
  localparam int ROWS      = BUF_BYTES / BANKS;
  localparam int EVT_BYTES = 3;

  localparam int CABLE_W = 4;
  localparam int TMO_W   = 16;
  localparam logic [TMO_W-1:0] TIMEOUT_RESET = 16'd1000;
  localparam logic [TMO_W-1:0] IDLE_MAX      = 16'hffff;

  // SysEx and real-time byte values.
  localparam logic [7:0] SYX_START = 8'hf0;
  localparam logic [7:0] SYX_END   = 8'hf7;
  localparam logic [7:0] RT_FIRST  = 8'hf8;

  // Code index numbers of interest.
  localparam logic [3:0] CIN_SYX_CONT = 4'd4;
  localparam logic [3:0] CIN_SYX_END1 = 4'd5;
  localparam logic [3:0] CIN_SYX_END2 = 4'd6;
  localparam logic [3:0] CIN_SYX_END3 = 4'd7;
  localparam logic [3:0] CIN_SINGLE   = 4'd15;

  typedef enum logic [2:0] {
    OP_EVENT     = 3'd0,
    OP_READ      = 3'd1,
    OP_RELEASE   = 3'd2,
    OP_ABORT     = 3'd3,
    OP_BUS_RESET = 3'd4,
    OP_TICK      = 3'd5
  } op_t;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] header_byte;
    logic [7:0] data_a;
    logic [7:0] data_b;
    logic [7:0] data_c;
    logic [7:0] read_index;
  } item_t;

  typedef struct packed {
    logic [CABLE_W-1:0] cable_number;
    logic [TMO_W-1:0]   timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic [CNT_W-1:0] fill_level;
    logic [CNT_W-1:0] mailbox_length;
    logic             in_message;
    logic [TMO_W-1:0] idle_ms;
  } state_t;

  typedef struct packed {
    logic [8:0] ready_length;
    logic       receiving;
    logic [8:0] fill_count;
    logic [7:0] read_data;
    logic       message_done;
    logic       frame_error;
  } result_t;

  typedef struct packed {
    logic             we;
    logic [ROW_W-1:0] row;
    logic [7:0]       data;
  } bank_wr_t;

endpackage

[hdl/umsr_apb_regs.sv]
// APB-style configuration registers of the SysEx reassembler.
// Depends on umsr_pkg for the register struct and reset values.
module umsr_apb_regs (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [2:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready,
  output umsr_pkg::cfg_t      cfg
);

  localparam logic REG_CABLE   = 1'b0;
  localparam logic REG_TIMEOUT = 1'b1;

  logic [umsr_pkg::CABLE_W-1:0] cable_r, cable_nxt;
  logic [umsr_pkg::TMO_W-1:0]   timeout_r, timeout_nxt;
  logic                         wr_hit;

  assign cfg_pready = 1'b1;
  assign wr_hit     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_comb begin
    cable_nxt   = cable_r;
    timeout_nxt = timeout_r;
    if (wr_hit) begin
      unique case (cfg_paddr[2])
        REG_CABLE:   cable_nxt   = cfg_pwdata[umsr_pkg::CABLE_W-1:0];
        REG_TIMEOUT: timeout_nxt = cfg_pwdata[umsr_pkg::TMO_W-1:0];
        default:     cable_nxt   = cable_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_CABLE:   cfg_prdata = {{(32-umsr_pkg::CABLE_W){1'b0}}, cable_r};
      REG_TIMEOUT: cfg_prdata = {{(32-umsr_pkg::TMO_W){1'b0}}, timeout_r};
      default:     cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cable_r   <= '0;
      timeout_r <= umsr_pkg::TIMEOUT_RESET;
    end else begin
      cable_r   <= cable_nxt;
      timeout_r <= timeout_nxt;
    end
  end

  assign cfg.cable_number = cable_r;
  assign cfg.timeout_ms   = timeout_r;

endmodule

[hdl/umsr_bank_ram.sv]
// One byte bank of the message buffer: one write port, one registered read.
// Depends on umsr_pkg for the bank geometry.
module umsr_bank_ram (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [umsr_pkg::ROW_W-1:0] wr_row,
  input  logic [7:0]                 wr_data,
  input  logic                       rd_en,
  input  logic [umsr_pkg::ROW_W-1:0] rd_row,
  output logic [7:0]                 rd_data
);

  logic [7:0] mem_r [umsr_pkg::ROWS];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_row] <= wr_data;
    end
  end

  // A read in the same cycle as a write to the same row sees the new byte.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= (wr_en && (wr_row == rd_row)) ? wr_data : mem_r[rd_row];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[hdl/umsr_event_core.sv]
// Next-state and result logic for one item of the SysEx reassembler.
// Depends on umsr_pkg for item, state, result and bank write types.
module umsr_event_core (
  input  umsr_pkg::item_t                       item,
  input  umsr_pkg::state_t                      st,
  input  umsr_pkg::cfg_t                        cfg,
  input  logic [7:0]                            rd_byte,
  input  logic                                  second_pass,
  output umsr_pkg::state_t                      st_nxt,
  output umsr_pkg::result_t                     res,
  output umsr_pkg::bank_wr_t [umsr_pkg::BANKS-1:0] bank_wr,
  output logic                                  split
);

  always_comb begin
    logic [3:0]                  cin;
    logic [7:0]                  b [umsr_pkg::EVT_BYTES];
    logic [1:0]                  cnt;
    logic [7:0]                  last_b;
    logic                        stop;
    logic [umsr_pkg::CNT_W-1:0]  f;
    logic [umsr_pkg::CNT_W-1:0]  mb;
    logic                        inm;
    logic [umsr_pkg::TMO_W-1:0]  idl;
    logic                        done;
    logic                        err;
    logic [7:0]                  rd;
    logic                        we [umsr_pkg::EVT_BYTES];
    logic                        keep [umsr_pkg::EVT_BYTES];
    logic [umsr_pkg::ADDR_W-1:0] wa [umsr_pkg::EVT_BYTES];
    logic [1:0]                  last_rs;
    logic                        clash;

    cin     = item.header_byte[3:0];
    b[0]    = item.data_a;
    b[1]    = item.data_b;
    b[2]    = item.data_c;
    f       = st.fill_level;
    mb      = st.mailbox_length;
    inm     = st.in_message;
    idl     = st.idle_ms;
    done    = 1'b0;
    err     = 1'b0;
    rd      = '0;
    stop    = 1'b0;
    last_rs = '0;
    clash   = 1'b0;
    for (int k = 0; k < umsr_pkg::EVT_BYTES; k++) begin
      we[k]   = 1'b0;
      keep[k] = 1'b0;
      wa[k]   = '0;
    end

    case (cin)
      umsr_pkg::CIN_SYX_CONT: cnt = 2'd3;
      umsr_pkg::CIN_SYX_END1: cnt = 2'd1;
      umsr_pkg::CIN_SYX_END2: cnt = 2'd2;
      umsr_pkg::CIN_SYX_END3: cnt = 2'd3;
      default:                cnt = 2'd0;
    endcase
    case (cnt)
      2'd1:    last_b = b[0];
      2'd2:    last_b = b[1];
      default: last_b = b[2];
    endcase

    unique case (umsr_pkg::op_t'(item.op))
      umsr_pkg::OP_EVENT: begin
        if (item.header_byte[7:4] == cfg.cable_number) begin
          if ((cin == umsr_pkg::CIN_SINGLE) && (b[0] >= umsr_pkg::RT_FIRST)) begin
            stop = 1'b1;
          end else if ((cin < umsr_pkg::CIN_SYX_CONT) || (cin > umsr_pkg::CIN_SYX_END3) ||
                       (mb != '0)) begin
            err = inm;
            inm = 1'b0;
            f   = '0;
          end else if ((cin != umsr_pkg::CIN_SYX_CONT) && (last_b != umsr_pkg::SYX_END)) begin
            err = inm;
            inm = 1'b0;
            f   = '0;
          end else begin
            // Walk the event bytes in order; a terminator or an error ends the walk.
            for (int k = 0; k < umsr_pkg::EVT_BYTES; k++) begin
              if (!stop && (k < int'(cnt))) begin
                if (b[k] == umsr_pkg::SYX_START) begin
                  inm     = 1'b1;
                  f       = '0;
                  idl     = '0;
                  last_rs = 2'(k);
                end
                if (inm) begin
                  if (b[k][7] && (b[k] != umsr_pkg::SYX_START) &&
                      (b[k] != umsr_pkg::SYX_END)) begin
                    err  = 1'b1;
                    inm  = 1'b0;
                    f    = '0;
                    stop = 1'b1;
                  end else if (f >= umsr_pkg::CNT_W'(umsr_pkg::BUF_BYTES)) begin
                    err  = 1'b1;
                    inm  = 1'b0;
                    f    = '0;
                    stop = 1'b1;
                  end else begin
                    we[k] = 1'b1;
                    wa[k] = f[umsr_pkg::ADDR_W-1:0];
                    f     = f + 1'b1;
                    if (b[k] == umsr_pkg::SYX_END) begin
                      if ((cin != umsr_pkg::CIN_SYX_CONT) && (k == int'(cnt) - 1)) begin
                        mb   = f;
                        done = 1'b1;
                      end else begin
                        err = 1'b1;
                      end
                      inm  = 1'b0;
                      f    = '0;
                      stop = 1'b1;
                    end
                  end
                end
              end
            end
          end
        end
      end
      umsr_pkg::OP_READ: begin
        // read_index always lies inside the buffer.
        rd = rd_byte;
      end
      umsr_pkg::OP_RELEASE: begin
        mb = '0;
      end
      umsr_pkg::OP_ABORT: begin
        err = inm;
        inm = 1'b0;
        f   = '0;
      end
      umsr_pkg::OP_BUS_RESET: begin
        err = inm;
        inm = 1'b0;
        f   = '0;
        mb  = '0;
        idl = '0;
      end
      umsr_pkg::OP_TICK: begin
        if (inm) begin
          if (idl != umsr_pkg::IDLE_MAX) begin
            idl = idl + 1'b1;
          end
          if (idl >= cfg.timeout_ms) begin
            err = 1'b1;
            inm = 1'b0;
            f   = '0;
          end
        end
      end
      default: begin
        stop = 1'b0;
      end
    endcase

    // A later byte of the same event at the same address supersedes an earlier one.
    for (int k = 0; k < umsr_pkg::EVT_BYTES; k++) begin
      keep[k] = we[k];
      for (int l = k + 1; l < umsr_pkg::EVT_BYTES; l++) begin
        if (we[l] && (wa[l] == wa[k])) begin
          keep[k] = 1'b0;
        end
      end
    end
    // Two surviving bytes in one bank can only come from a restart in the middle
    // of the event; such an event is written in two passes split at the restart.
    for (int k = 0; k < umsr_pkg::EVT_BYTES; k++) begin
      for (int l = k + 1; l < umsr_pkg::EVT_BYTES; l++) begin
        if (keep[k] && keep[l] &&
            (wa[k][umsr_pkg::BANK_W-1:0] == wa[l][umsr_pkg::BANK_W-1:0])) begin
          clash = 1'b1;
        end
      end
    end
    if (clash) begin
      for (int k = 0; k < umsr_pkg::EVT_BYTES; k++) begin
        if (second_pass) begin
          keep[k] = keep[k] && (k >= int'(last_rs));
        end else begin
          keep[k] = keep[k] && (k < int'(last_rs));
        end
      end
    end

    for (int j = 0; j < umsr_pkg::BANKS; j++) begin
      bank_wr[j] = '0;
      for (int k = 0; k < umsr_pkg::EVT_BYTES; k++) begin
        if (keep[k] && (wa[k][umsr_pkg::BANK_W-1:0] == umsr_pkg::BANK_W'(j))) begin
          bank_wr[j].we   = 1'b1;
          bank_wr[j].row  = wa[k][umsr_pkg::ADDR_W-1:umsr_pkg::BANK_W];
          bank_wr[j].data = b[k];
        end
      end
    end

    split                 = clash;
    st_nxt.fill_level     = f;
    st_nxt.mailbox_length = mb;
    st_nxt.in_message     = inm;
    st_nxt.idle_ms        = idl;
    res.ready_length      = mb;
    res.receiving         = inm;
    res.fill_count        = f;
    res.read_data         = rd;
    res.message_done      = done;
    res.frame_error       = err;
  end

endmodule

[hdl/usb_midi_sysex_reassembler.sv]
// Top level of the USB-MIDI SysEx reassembler: channels, pipeline and state.
// Depends on umsr_pkg, umsr_apb_regs, umsr_bank_ram and umsr_event_core.
//
// The input channel (in_*) carries one operation per item: an event packet,
// a buffer read, a mailbox release, an abort, a bus reset or a millisecond
// tick. The op code travels in in_tuser, the packet bytes and the read index
// in in_tdata. Every item produces exactly one result item on out_*, which
// reports the mailbox length, the collection state and fill count, the byte
// read, and whether this item completed or dropped a message.
// An accepted item waits in the input stage, where its buffer read has
// already been issued, and its result is registered into the output stage.
// Throughput is one item per cycle while the receiver takes results. The one
// exception is an event whose 0xF0 restarts a message in progress halfway
// through the packet: its bytes may need two writes to one of the four
// buffer banks, so it holds the input stage for a second write pass.
// When the receiver stalls, the result waits in the output register and the
// next item is still taken into the input stage; only then does in_tready drop.
// Reset (rst_n low, synchronous) empties both stages, the mailbox and the
// partial message and restores the configuration defaults (cable 0, timeout
// 1000 ms). Buffer contents are not cleared. Configuration goes through the
// APB port at byte addresses 0 (cable number) and 4 (timeout in ms).
module usb_midi_sysex_reassembler (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel. in_tdata, from bit 0 up: header_byte, data_a, data_b,
  // data_c, read_index.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,
  // in_tuser: op.
  input  logic [2:0]  in_tuser,
  // Result channel. out_tdata, from bit 0 up: ready_length, receiving,
  // fill_count, read_data, message_done, frame_error, zero fill.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,
  // Configuration port.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  umsr_pkg::cfg_t    cfg;
  umsr_pkg::item_t   in_item;
  umsr_pkg::item_t   s1_item_r;
  logic              s1_valid_r, s1_valid_nxt;
  logic              phase_r, phase_nxt;
  umsr_pkg::state_t  st_r, st_nxt, core_st;
  logic              out_valid_r, out_valid_nxt;
  logic [31:0]       out_data_r;
  umsr_pkg::result_t core_res;
  umsr_pkg::bank_wr_t [umsr_pkg::BANKS-1:0] bank_wr;
  logic [7:0]        bank_rd [umsr_pkg::BANKS];
  logic              split;
  logic              hold_first;
  logic              s1_go;
  logic              in_take;
  logic              mem_wen;

  umsr_apb_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  assign in_item.op          = in_tuser;
  assign in_item.header_byte = in_tdata[7:0];
  assign in_item.data_a      = in_tdata[15:8];
  assign in_item.data_b      = in_tdata[23:16];
  assign in_item.data_c      = in_tdata[31:24];
  assign in_item.read_index  = in_tdata[39:32];

  // The input stage moves on when its result has a free output slot, except
  // in the first cycle of a two-pass event.
  assign hold_first = split && !phase_r;
  assign s1_go      = s1_valid_r && !hold_first && (!out_valid_r || out_tready);
  assign in_tready  = !s1_valid_r || s1_go;
  assign in_take    = in_tvalid && in_tready;
  assign mem_wen    = s1_valid_r && (hold_first || s1_go);

  umsr_event_core u_core (
    .item        (s1_item_r),
    .st          (st_r),
    .cfg         (cfg),
    .rd_byte     (bank_rd[s1_item_r.read_index[umsr_pkg::BANK_W-1:0]]),
    .second_pass (phase_r),
    .st_nxt      (core_st),
    .res         (core_res),
    .bank_wr     (bank_wr),
    .split       (split)
  );

  // All banks read the row of the incoming item's index as it is accepted;
  // the bank is picked once the item reaches the input stage.
  for (genvar j = 0; j < umsr_pkg::BANKS; j++) begin : g_bank
    umsr_bank_ram u_bank (
      .clk     (clk),
      .wr_en   (mem_wen && bank_wr[j].we),
      .wr_row  (bank_wr[j].row),
      .wr_data (bank_wr[j].data),
      .rd_en   (in_take),
      .rd_row  (in_item.read_index[umsr_pkg::ADDR_W-1:umsr_pkg::BANK_W]),
      .rd_data (bank_rd[j])
    );
  end

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    phase_nxt     = phase_r;
    st_nxt        = st_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (s1_go) begin
      s1_valid_nxt  = 1'b0;
      phase_nxt     = 1'b0;
      st_nxt        = core_st;
      out_valid_nxt = 1'b1;
    end else if (s1_valid_r && hold_first) begin
      phase_nxt = 1'b1;
    end
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      phase_r     <= 1'b0;
      st_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      phase_r     <= phase_nxt;
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= in_item;
    end
    if (s1_go) begin
      out_data_r <= {3'b000,
                     core_res.frame_error,
                     core_res.message_done,
                     core_res.read_data,
                     core_res.fill_count,
                     core_res.receiving,
                     core_res.ready_length};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for usb_midi_sysex_reassembler: directed and random items.
// Depends on umsr_pkg and the RTL under hdl; it uses no other file.
module tb;
  import umsr_pkg::*;

  // APB byte addresses of the two configuration registers.
  localparam logic [2:0] REG_CABLE   = 3'd0;
  localparam logic [2:0] REG_TIMEOUT = 3'd4;
  // Cycles without any handshake on either channel before the run is declared hung.
  localparam int QUIET_LIMIT = 1000;
  // Idle wait before a configuration change and at the end of the run.
  localparam int SETTLE_CYCLES = 4;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  // in_tdata, from bit 0 up: header_byte, data_a, data_b, data_c, read_index.
  logic [39:0] in_tdata = '0;
  // in_tuser: op.
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b1;
  // out_tdata, from bit 0 up: ready_length, receiving, fill_count, read_data,
  // message_done, frame_error, zero fill.
  logic [31:0] out_tdata;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  usb_midi_sysex_reassembler u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow of the reassembler. It mirrors the configuration, the partial
  // message, the mailbox and the buffer, and it remembers which buffer
  // entries have ever been written so that reads only go to those.
  // ---------------------------------------------------------------------------
  logic [3:0]  cur_cable = 4'd0;
  logic [15:0] cur_timeout = TIMEOUT_RESET;
  int          fill_bytes = 0;
  int          mailbox_len = 0;
  bit          collecting = 1'b0;
  int          idle_ticks = 0;
  logic [7:0]  sysex_buf [0:BUF_BYTES-1];
  bit          sysex_written [0:BUF_BYTES-1];

  result_t     results_due [$];   // one awaited result per accepted item, oldest first
  int          mismatch_count = 0;
  int          items_sent = 0;
  int          quiet_cycles = 0;
  int          stall_left = 0;
  bit          calm = 1'b0;       // when set, neither side inserts idle cycles
  logic [7:0]  tx_bytes [$];      // SysEx byte stream waiting to be cut into events
  result_t     seen, oldest;

  // Drops the partial message and tells whether one was in progress.
  function automatic bit abandon_message();
    bit was;
    was = collecting;
    collecting = 1'b0;
    fill_bytes = 0;
    return was;
  endfunction

  // Applies one operation to the shadow state and returns the result it must produce.
  function automatic result_t reassemble(input op_t op, input logic [7:0] hdr, a, b, c,
                                         input logic [7:0] idx);
    result_t    r;
    logic [7:0] pkt [3];
    logic [3:0] cin;
    logic [7:0] bv;
    int         cnt;
    bit         finished;
    bit         done;
    bit         err;
    r = '0;
    done = 1'b0;
    err = 1'b0;
    pkt[0] = a;
    pkt[1] = b;
    pkt[2] = c;
    cin = hdr[3:0];
    case (op)
      OP_EVENT: begin
        // Other cables and real-time bytes pass through untouched.
        if (hdr[7:4] == cur_cable && !(cin == CIN_SINGLE && a >= RT_FIRST)) begin
          if (cin < CIN_SYX_CONT || cin > CIN_SYX_END3 || mailbox_len != 0) begin
            err = abandon_message();
          end else begin
            cnt = (cin == CIN_SYX_CONT) ? 3 : int'(cin - CIN_SYX_CONT);
            if (cin != CIN_SYX_CONT && pkt[cnt-1] != SYX_END) begin
              err = abandon_message();
            end else begin
              finished = 1'b0;
              for (int i = 0; i < cnt && !finished; i++) begin
                bv = pkt[i];
                if (bv == SYX_START) begin
                  collecting = 1'b1;
                  fill_bytes = 0;
                  idle_ticks = 0;
                end
                if (collecting) begin
                  if (bv[7] && bv != SYX_START && bv != SYX_END) begin
                    err = abandon_message();
                    finished = 1'b1;
                  end else if (fill_bytes >= BUF_BYTES) begin
                    err = abandon_message();
                    finished = 1'b1;
                  end else begin
                    sysex_buf[fill_bytes] = bv;
                    sysex_written[fill_bytes] = 1'b1;
                    fill_bytes++;
                    if (bv == SYX_END) begin
                      finished = 1'b1;
                      // Only a terminator closing an end packet completes the message.
                      if (cin != CIN_SYX_CONT && i == cnt - 1) begin
                        mailbox_len = fill_bytes;
                        done = 1'b1;
                        void'(abandon_message());
                      end else begin
                        err = abandon_message();
                      end
                    end
                  end
                end
              end
            end
          end
        end
      end
      OP_READ:      r.read_data = sysex_buf[idx];
      OP_RELEASE:   mailbox_len = 0;
      OP_ABORT:     err = abandon_message();
      OP_BUS_RESET: begin
        err = abandon_message();
        mailbox_len = 0;
        idle_ticks = 0;
      end
      OP_TICK: begin
        if (collecting) begin
          if (idle_ticks < int'(IDLE_MAX)) idle_ticks++;
          if (idle_ticks >= int'(cur_timeout)) err = abandon_message();
        end
      end
      default: ;
    endcase
    r.ready_length = 9'(mailbox_len);
    r.receiving    = collecting;
    r.fill_count   = 9'(fill_bytes);
    r.message_done = done;
    r.frame_error  = err;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // Mostly short gaps, now and then a long one.
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 8);
    return $urandom_range(10, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure and the field-by-field comparison.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_tready <= 1'b1;
      if (!calm && $urandom_range(0, 99) < 20) stall_left <= idle_length();
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen.ready_length = out_tdata[8:0];
      seen.receiving    = out_tdata[9];
      seen.fill_count   = out_tdata[18:10];
      seen.read_data    = out_tdata[26:19];
      seen.message_done = out_tdata[27];
      seen.frame_error  = out_tdata[28];
      if (results_due.size() == 0) begin
        report_mismatch("result with nothing outstanding", out_tdata, 0);
      end else begin
        oldest = results_due.pop_front();
        if (seen.ready_length !== oldest.ready_length)
          report_mismatch("ready_length", seen.ready_length, oldest.ready_length);
        if (seen.receiving !== oldest.receiving)
          report_mismatch("receiving", seen.receiving, oldest.receiving);
        if (seen.fill_count !== oldest.fill_count)
          report_mismatch("fill_count", seen.fill_count, oldest.fill_count);
        if (seen.read_data !== oldest.read_data)
          report_mismatch("read_data", seen.read_data, oldest.read_data);
        if (seen.message_done !== oldest.message_done)
          report_mismatch("message_done", seen.message_done, oldest.message_done);
        if (seen.frame_error !== oldest.frame_error)
          report_mismatch("frame_error", seen.frame_error, oldest.frame_error);
      end
    end
  end

  // A hung handshake ends the run instead of letting it spin forever.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
      $display("** usb_midi_sysex_reassembler: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Input side. The item is predicted at the edge where it is accepted. When
  // no gap follows, tvalid simply stays high for the next item.
  // ---------------------------------------------------------------------------
  task automatic send_item(input op_t op, input logic [7:0] hdr, a, b, c, idx);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {idx, c, b, a, hdr};
    do @(posedge clk); while (!in_tready);
    results_due.push_back(reassemble(op, hdr, a, b, c, idx));
    items_sent++;
    gap = (calm || $urandom_range(0, 99) < 55) ? 0 : idle_length();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Any operation except a read, with random filler in the unused fields.
  task automatic send_op(input op_t op);
    send_item(op, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic send_event(input logic [3:0] cin, input logic [7:0] a, b, c);
    send_item(OP_EVENT, {cur_cable, cin}, a, b, c, 8'($urandom));
  endtask

  // Reads a buffer entry that has been written; a tick stands in while none has.
  task automatic read_written();
    int idx;
    idx = $urandom_range(0, BUF_BYTES - 1);
    for (int k = 0; k < BUF_BYTES && !sysex_written[idx]; k++) idx = (idx + 1) % BUF_BYTES;
    if (sysex_written[idx]) send_item(OP_READ, 8'($urandom), 8'($urandom), 8'($urandom),
                                      8'($urandom), 8'(idx));
    else send_op(OP_TICK);
  endtask

  // Holds the sender until every outstanding result has come back.
  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
  endtask

  // APB write followed by a read-back of the same register.
  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (cfg_prdata !== data) report_mismatch("register read-back", cfg_prdata, data);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic set_config(input logic [3:0] cable, input logic [15:0] timeout);
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    apb_write(REG_CABLE, {28'd0, cable});
    apb_write(REG_TIMEOUT, {16'd0, timeout});
    cur_cable   = cable;
    cur_timeout = timeout;
  endtask

  // Fills tx_bytes with optional loose data bytes, 0xF0, data bytes and 0xF7.
  task automatic build_message(input int lead_in, input int data_len);
    tx_bytes.delete();
    repeat (lead_in) tx_bytes.push_back(8'($urandom_range(0, 127)));
    tx_bytes.push_back(SYX_START);
    repeat (data_len) tx_bytes.push_back(8'($urandom_range(0, 127)));
    tx_bytes.push_back(SYX_END);
  endtask

  // Harmless noise that leaves a message in progress alone, apart from the
  // timeout that ticks advance. Harsh noise also aborts, releases and breaks.
  task automatic send_noise(input bit harsh);
    logic [3:0] cin;
    case ($urandom_range(0, harsh ? 7 : 3))
      0: send_op(OP_TICK);
      1: send_item(OP_EVENT, {cur_cable ^ 4'($urandom_range(1, 15)), 4'($urandom)},
                   8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      2: send_event(CIN_SINGLE, 8'($urandom_range(RT_FIRST, 255)), 8'($urandom),
                    8'($urandom));
      3: read_written();
      4: begin
        cin = 4'($urandom_range(0, 11));
        if (cin >= CIN_SYX_CONT) cin = cin + 4'd4;
        send_event(cin, (cin == CIN_SINGLE) ? 8'($urandom_range(0, RT_FIRST - 1))
                                            : 8'($urandom), 8'($urandom), 8'($urandom));
      end
      5: send_op(OP_ABORT);
      6: send_op(OP_RELEASE);
      default: send_event(CIN_SYX_CONT, 8'($urandom), 8'($urandom), 8'($urandom));
    endcase
  endtask

  // Cuts tx_bytes into event packets: continuation packets of three bytes and
  // a final packet that carries the rest. With natural_end the final packet
  // gets the end code index for its byte count, otherwise end_cin. Unused
  // bytes of the final packet are random.
  task automatic send_stream(input bit natural_end, input logic [3:0] end_cin,
                             input int noise_pct);
    int         pos;
    int         left;
    int         n;
    logic [3:0] cin;
    logic [7:0] pkt [3];
    pos = 0;
    while (pos < tx_bytes.size()) begin
      left = tx_bytes.size() - pos;
      n = (left > 3) ? 3 : left;
      for (int j = 0; j < 3; j++) pkt[j] = (j < n) ? tx_bytes[pos+j] : 8'($urandom);
      if (left > 3) cin = CIN_SYX_CONT;
      else if (natural_end) cin = CIN_SYX_CONT + 4'(n);
      else cin = end_cin;
      send_event(cin, pkt[0], pkt[1], pkt[2]);
      pos += n;
      if (left > 3 && $urandom_range(0, 99) < noise_pct) send_noise(1'b0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Every operation and the corner cases of event handling, on the reset
  // configuration (cable 0, 1000 ms).
  task automatic test_event_corners();
    send_event(CIN_SYX_END3, SYX_START, 8'h01, SYX_END);     // complete in one packet
    send_item(OP_READ, 8'h00, 8'h00, 8'h00, 8'h00, 8'd0);
    send_item(OP_READ, 8'hff, 8'hff, 8'hff, 8'hff, 8'd2);
    send_event(CIN_SYX_CONT, SYX_START, 8'h10, 8'h11);        // mailbox still full
    send_op(OP_RELEASE);
    send_event(CIN_SYX_END2, SYX_START, SYX_END, 8'h55);
    send_op(OP_RELEASE);
    send_event(CIN_SYX_END1, SYX_END, 8'h00, 8'h00);          // terminator outside a message
    send_event(CIN_SYX_CONT, SYX_START, 8'h7f, 8'h00);
    send_event(CIN_SYX_CONT, SYX_END, 8'h01, 8'h02);          // terminator in a continuation
    send_event(CIN_SYX_CONT, SYX_START, 8'h01, 8'h02);
    send_event(CIN_SYX_END2, 8'h03, 8'h05, 8'h00);            // last byte is not 0xF7
    send_event(CIN_SYX_CONT, SYX_START, 8'h01, 8'h02);
    send_event(CIN_SYX_CONT, 8'h03, 8'h80, 8'h04);            // stray status byte
    send_event(CIN_SYX_CONT, SYX_START, 8'h01, 8'h02);
    send_event(4'd2, 8'h03, 8'h04, 8'h05);                    // code index outside 4..7
    send_event(CIN_SYX_CONT, SYX_START, 8'h01, 8'h02);
    send_event(CIN_SINGLE, RT_FIRST, 8'h00, 8'h00);           // real-time byte, skipped
    send_event(CIN_SINGLE, SYX_START, 8'h00, 8'h00);          // other single-byte event
    send_item(OP_EVENT, {4'd7, CIN_SYX_END3}, SYX_START, 8'h01, SYX_END, 8'h00);
    send_event(CIN_SYX_CONT, SYX_START, 8'h01, 8'h02);
    send_event(CIN_SYX_CONT, 8'h03, SYX_START, 8'h04);        // restart halfway through
    send_event(CIN_SYX_END3, 8'h05, 8'h06, SYX_END);
    send_item(OP_READ, 8'h00, 8'h00, 8'h00, 8'h00, 8'd4);
    send_event(CIN_SYX_CONT, SYX_START, 8'h00, 8'h00);
    send_op(OP_BUS_RESET);                                    // empties the mailbox
    send_op(OP_ABORT);                                        // nothing to abort
    send_event(CIN_SYX_CONT, SYX_START, 8'h7f, 8'h7f);
    send_op(OP_TICK);
    send_op(OP_ABORT);
    send_event(CIN_SYX_CONT, SYX_START, 8'h01, 8'h02);
    send_op(OP_BUS_RESET);
  endtask

  // A message that fills the buffer exactly, then two that overflow it, on
  // the highest cable; the first is sent with no idling on either side.
  task automatic test_full_buffer();
    set_config(4'd15, 16'hffff);
    calm = 1'b1;
    build_message(0, BUF_BYTES - 2);
    send_stream(1'b1, CIN_SYX_CONT, 0);
    send_item(OP_READ, 8'h00, 8'h00, 8'h00, 8'h00, 8'(BUF_BYTES - 1));
    send_item(OP_READ, 8'h00, 8'h00, 8'h00, 8'h00, 8'd0);
    calm = 1'b0;
    repeat (6) read_written();
    send_op(OP_RELEASE);
    build_message(0, BUF_BYTES - 1);                          // terminator is one too many
    send_stream(1'b1, CIN_SYX_CONT, 0);
    build_message(0, BUF_BYTES + 40);                         // data byte overflows
    send_stream(1'b1, CIN_SYX_CONT, 0);
  endtask

  // Timeout at its lowest setting, a small one with a restart in between,
  // and the highest one; bus reset also clears the elapsed time.
  task automatic test_timeout();
    set_config(4'd9, 16'd1);
    send_event(CIN_SYX_CONT, SYX_START, 8'h01, 8'h02);
    send_op(OP_TICK);
    send_op(OP_TICK);                                         // nothing left to time out
    set_config(4'd9, 16'd3);
    send_event(CIN_SYX_CONT, SYX_START, 8'h01, 8'h02);
    repeat (2) send_op(OP_TICK);
    send_event(CIN_SYX_CONT, 8'h03, SYX_START, 8'h04);        // restart clears the time
    repeat (3) send_op(OP_TICK);
    send_event(CIN_SYX_CONT, SYX_START, 8'h01, 8'h02);
    repeat (2) send_op(OP_TICK);
    send_op(OP_BUS_RESET);
    send_event(CIN_SYX_CONT, SYX_START, 8'h01, 8'h02);
    repeat (2) send_op(OP_TICK);
    send_event(CIN_SYX_END1, SYX_END, 8'h00, 8'h00);
    send_op(OP_RELEASE);
    set_config(4'd0, 16'hffff);
    send_event(CIN_SYX_CONT, SYX_START, 8'h01, 8'h02);
    repeat (5) send_op(OP_TICK);
    send_event(CIN_SYX_END2, 8'h03, SYX_END, 8'h00);
    send_op(OP_RELEASE);
  endtask

  // Mostly well-formed messages with random content and random noise in
  // between; the rest are damaged messages, noise bursts and resets.
  task automatic test_random_traffic(input logic [3:0] cable, input logic [15:0] timeout,
                                     input int count);
    int         stop_at;
    int         pick;
    int         len;
    int         at;
    bit         natural_end;
    logic [3:0] end_cin;
    set_config(cable, timeout);
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      len = $urandom_range(0, 99);
      len = (len < 85) ? $urandom_range(0, 24) :
            (len < 98) ? $urandom_range(25, 90) : $urandom_range(BUF_BYTES - 16, BUF_BYTES + 2);
      // A completed message is usually read a little and released; now and
      // then traffic runs into the full mailbox instead.
      if (mailbox_len != 0 && $urandom_range(0, 9) != 0) begin
        repeat ($urandom_range(0, 2)) read_written();
        send_op(OP_RELEASE);
      end else if (pick < 60) begin
        build_message(($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0, len);
        send_stream(1'b1, CIN_SYX_CONT, 15);
      end else if (pick < 75) begin
        build_message($urandom_range(0, 2), len);
        at = $urandom_range(0, tx_bytes.size() - 1);
        natural_end = 1'b1;
        end_cin = CIN_SYX_CONT;
        case ($urandom_range(0, 3))
          0: tx_bytes[at] = 8'($urandom);
          1: tx_bytes.insert(at, SYX_START);
          2: natural_end = 1'b0;                              // ends on a continuation
          default: begin
            natural_end = 1'b0;
            end_cin = 4'($urandom);
          end
        endcase
        send_stream(natural_end, end_cin, 15);
      end else if (pick < 97) begin
        repeat ($urandom_range(1, 4)) send_noise(1'b1);
      end else begin
        send_op(($urandom_range(0, 1) != 0) ? OP_BUS_RESET : OP_ABORT);
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_event_corners();
    test_full_buffer();
    test_timeout();
    test_random_traffic(4'd5, 16'd40, 375);
    test_random_traffic(4'd15, 16'hffff, 375);
    test_random_traffic(4'd0, 16'd12, 375);
    test_random_traffic(4'($urandom), 16'($urandom_range(1, 65535)), 375);
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("** usb_midi_sysex_reassembler: PASSED **");
    end else begin
      $display("** usb_midi_sysex_reassembler: FAILED **");
    end
    $finish;
  end

endmodule
